// File: sv/lruts_pkg.sv
// Shared types and constants for the timestamp LRU victim selector.
package lruts_pkg;

  localparam int DEF_SETS  = 64;
  localparam int DEF_WAYS  = 16;
  localparam int SET_IDX_W = 6;
  localparam int WAY_IDX_W = 4;
  localparam int STAMP_W   = 64;
  localparam int VICTIM_W  = 4;

  typedef enum logic {
    CMD_QUERY  = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_code_t;

  typedef struct packed {
    logic clear_we;
    logic query_go;
    logic update_go;
    logic scan_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
  } dp_status_t;

endpackage

// File: sv/lruts_ctrl.sv
// Controller state machine for the timestamp LRU victim selector.
module lruts_ctrl
  import lruts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       cmd,
  input  dp_status_t status,
  output ctrl_cmd_t  ctl,
  output logic       busy,
  output logic       done
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state == ST_CLEAR) || (state == ST_SCAN);
  assign done   = (state == ST_DONE);
  assign accept = start && !busy;

  always_comb begin
    ctl.clear_we  = (state == ST_CLEAR);
    ctl.query_go  = accept && (cmd_code_t'(cmd) == CMD_QUERY);
    ctl.update_go = accept && (cmd_code_t'(cmd) == CMD_UPDATE);
    ctl.scan_step = (state == ST_SCAN);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE, ST_DONE: begin
        state_next = ctl.query_go ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (status.scan_last) state_next = ST_DONE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/lruts_dp.sv
// Datapath: per-way timestamp memories, clearing counter and minimum scan.
module lruts_dp
  import lruts_pkg::*;
#(
  parameter int SETS = DEF_SETS,
  parameter int WAYS = DEF_WAYS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            ctl,
  input  logic [SET_IDX_W-1:0] set_index,
  input  logic [WAY_IDX_W-1:0] way_index,
  input  logic [STAMP_W-1:0]   cycle_now,
  output dp_status_t           status,
  output logic [VICTIM_W-1:0]  lru_way
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = $clog2(WAYS);

  logic [SET_W-1:0]   clr_addr;
  logic [SET_W-1:0]   addr;
  logic [WAY_W-1:0]   upd_way;
  logic               set_in_range;
  logic               way_in_range;
  logic [WAY_W-1:0]   scan_idx;
  logic [WAY_W-1:0]   best_idx;
  logic               set_ok;
  logic [STAMP_W-1:0] rdata [WAYS];

  assign addr         = SET_W'(set_index);
  assign upd_way      = WAY_W'(way_index);
  assign set_in_range = 32'(set_index) < SETS;
  assign way_in_range = 32'(way_index) < WAYS;

  for (genvar g = 0; g < WAYS; g++) begin : g_bank
    logic [STAMP_W-1:0] mem [SETS];
    logic               upd_we;

    assign upd_we = ctl.update_go && set_in_range && way_in_range &&
                    (upd_way == WAY_W'(g));

    always_ff @(posedge clk) begin
      if (ctl.clear_we) begin
        mem[clr_addr] <= '0;
      end else if (upd_we) begin
        mem[addr] <= cycle_now;
      end
      if (ctl.query_go) begin
        rdata[g] <= mem[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clear_we) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      best_idx <= '0;
      set_ok   <= 1'b0;
    end else if (ctl.query_go) begin
      scan_idx <= WAY_W'(1);
      best_idx <= '0;
      set_ok   <= set_in_range;
    end else if (ctl.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      if (rdata[scan_idx] < rdata[best_idx]) begin
        best_idx <= scan_idx;
      end
    end
  end

  always_comb begin
    status.clear_last = (clr_addr == SET_W'(SETS - 1));
    status.scan_last  = (scan_idx == WAY_W'(WAYS - 1));
  end

  assign lru_way = set_ok ? VICTIM_W'(best_idx) : '0;

endmodule

// File: sv/timestamp_lru_victim_select_top.sv
// Top level of the timestamp LRU victim selector.
//
//  Channel   Handshake           Signals
//  request   start && !busy      cmd, set_index, way_index, cycle_now
//  result    done (one cycle)    lru_way
//
// An update request leaves busy low, so updates may come every cycle.
// A victim query keeps busy high while one way per cycle is compared against the running
// minimum; the result shows in the following cycle, in which the next request can already
// be taken.
// After reset a clearing pass writes one set per cycle through all SETS sets with busy high.
// The receiver cannot stall; each result is valid for exactly the cycle done is high.
module timestamp_lru_victim_select_top
  import lruts_pkg::*;
#(
  parameter int SETS = DEF_SETS,
  parameter int WAYS = DEF_WAYS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cmd,
  input  logic [SET_IDX_W-1:0] set_index,
  input  logic [WAY_IDX_W-1:0] way_index,
  input  logic [STAMP_W-1:0]   cycle_now,
  output logic                 done,
  output logic [VICTIM_W-1:0]  lru_way
);

  ctrl_cmd_t  ctl;
  dp_status_t status;

  lruts_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .status (status),
    .ctl    (ctl),
    .busy   (busy),
    .done   (done)
  );

  lruts_dp #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .set_index (set_index),
    .way_index (way_index),
    .cycle_now (cycle_now),
    .status    (status),
    .lru_way   (lru_way)
  );

`ifndef SYNTHESIS
  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("clearing pass did not start after reset");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd_code_t'(cmd) == CMD_QUERY)) |=> busy)
    else $error("query request did not make the block busy");

  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  a_victim_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(lru_way) < WAYS))
    else $error("victim way beyond the way count");
`endif

endmodule
